>>> hdl/pao_pkg.sv
`default_nettype none
package pao_pkg;
   localparam int FRAC_BITS_DEF = 13;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_COUNT = 28;

   localparam logic [2:0] CSR_COEF_A = 3'd0;
   localparam logic [2:0] CSR_COEF_B = 3'd1;
   localparam logic [2:0] CSR_COEF_C = 3'd2;
   localparam logic [2:0] CSR_COEF_D = 3'd3;
   localparam logic [2:0] CSR_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_HEIGHT = 3'd5;

   // angle datapath width: holds the scaled angle products
   localparam int AW = 48;
   localparam logic signed [AW-1:0] Q30_PI      = 48'sd3373259426;
   localparam logic signed [AW-1:0] Q30_TWO_PI  = 48'sd6746518852;
   localparam logic signed [AW-1:0] Q30_HALF_PI = 48'sd1686629713;
   localparam logic signed [AW-1:0] CORDIC_GAIN = 48'sd652032874;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SCALE, ST_REDUCE, ST_FOLD, ST_ROT, ST_STORE,
      ST_SUM, ST_PIX, ST_DIV, ST_DONE
   } state_type;

   function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: return 48'sd843314856;
         5'd1: return 48'sd497837829;
         5'd2: return 48'sd263043836;
         5'd3: return 48'sd133525158;
         5'd4: return 48'sd67021686;
         5'd5: return 48'sd33543515;
         5'd6: return 48'sd16775850;
         5'd7: return 48'sd8388437;
         5'd8: return 48'sd4194282;
         5'd9: return 48'sd2097149;
         5'd10: return 48'sd1048575;
         5'd11: return 48'sd524287;
         5'd12: return 48'sd262143;
         5'd13: return 48'sd131071;
         5'd14: return 48'sd65535;
         5'd15: return 48'sd32767;
         5'd16: return 48'sd16383;
         5'd17: return 48'sd8191;
         5'd18: return 48'sd4095;
         5'd19: return 48'sd2047;
         5'd20: return 48'sd1023;
         5'd21: return 48'sd511;
         5'd22: return 48'sd255;
         5'd23: return 48'sd127;
         5'd24: return 48'sd63;
         5'd25: return 48'sd31;
         5'd26: return 48'sd15;
         5'd27: return 48'sd7;
         default: return 48'sd0;
      endcase
   endfunction
endpackage
`default_nettype wire

>>> hdl/pao_cordic.sv
`default_nettype none
// Rotation CORDIC, one micro-rotation per cycle while busy, reusing the same add/sub logic.
module pao_cordic #(
   parameter int CORDIC_STAGES = pao_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [pao_pkg::AW-1:0]   angle,
   output logic                                 done,
   output logic signed [pao_pkg::AW-1:0]        sin_out,
   output logic signed [pao_pkg::AW-1:0]        cos_out
);
   import pao_pkg::*;
   localparam int NST = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

   logic signed [AW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic busy_ff, busy_in;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff; busy_in = busy_ff;
      done = 1'b0;
      if (start) begin
         x_in = CORDIC_GAIN; y_in = '0; z_in = angle; i_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[AW-1]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - atan_q30(i_ff);
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + atan_q30(i_ff);
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(NST - 1)) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   assign sin_out = y_in;
   assign cos_out = x_in;

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
   end
endmodule
`default_nettype wire

>>> hdl/pickover_attractor_point_step.sv
`default_nettype none
// Pickover attractor stepper. Each request beat advances the stored point one map step
// and returns one response beat with the new point, its screen pixel and an on-screen
// flag. Coefficients and screen size sit in six CSRs, to be written only while idle; the
// block does not enforce this. The block works on one beat at a time: four sine/cosine
// evaluations share one iterative CORDIC, each angle passing through multiply, scale,
// a range check that takes off 2*pi until the angle lies in (-pi, pi] (more often at
// small FRAC_BITS), fold, rotation and store. Rounding of both coordinates, the two pixel
// divides (shift, then reciprocal multiply by 1/3) and the loading of the response
// register follow. The next request can be taken in the same cycle that the response
// becomes valid. A new request is taken while an earlier response waits; a finished
// step holds until the response register frees up.
module pickover_attractor_point_step #(
   parameter int FRAC_BITS = pao_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = pao_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_restart,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_point_x,
   output logic signed [15:0]      rsp_point_y,
   output logic signed [13:0]      rsp_pixel_x,
   output logic signed [13:0]      rsp_pixel_y,
   output logic                    rsp_on_screen,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   import pao_pkg::*;

   localparam int SH = 2 * FRAC_BITS - 30;
   localparam int PW = 72;   // sum/pixel numerator width
   localparam int DW = 48;   // pixel quotient width

   logic signed [15:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [11:0] sw_ff, sh_ff;
   logic signed [15:0] px_ff, py_ff;

   state_type st_ff, st_in;
   logic [1:0] k_ff, k_in;        // which of four angles
   logic signed [AW-1:0] z_ff, z_in;
   logic neg_ff, neg_in;
   logic signed [AW-1:0] s_ff [4];
   logic signed [AW-1:0] c_ff [4];
   logic signed [15:0] nx_ff, nx_in, ny_ff, ny_in;
   logic j_ff, j_in;              // which coordinate in sum/pixel
   logic signed [DW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   // pixel divide
   logic [31:0] dq_ff, dq_in;
   logic dneg_ff, dneg_in;

   logic rv_ff, rv_in;
   logic signed [15:0] ox_ff, ox_in, oy_ff, oy_in;
   logic signed [13:0] pxo_ff, pxo_in, pyo_ff, pyo_in;
   logic on_ff, on_in;

   logic cstart, cdone;
   logic signed [AW-1:0] csin, ccos;
   logic out_load;

   pao_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
      .clock, .reset, .start(cstart), .angle(z_in), .done(cdone),
      .sin_out(csin), .cos_out(ccos)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (st_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_point_x = ox_ff;
   assign rsp_point_y = oy_ff;
   assign rsp_pixel_x = pxo_ff;
   assign rsp_pixel_y = pyo_ff;
   assign rsp_on_screen = on_ff;
   assign out_load = (st_ff == ST_DONE) && (!rv_ff || !rsp_stall);

   // multiplier operands by angle index: a*y, a*x, b*x, b*y
   logic signed [15:0] mk, mu;
   always_comb begin
      case (k_ff)
         2'd0: begin mk = ca_ff; mu = py_ff; end
         2'd1: begin mk = ca_ff; mu = px_ff; end
         2'd2: begin mk = cb_ff; mu = px_ff; end
         default: begin mk = cb_ff; mu = py_ff; end
      endcase
   end

   logic signed [31:0] prod;
   logic signed [PW-1:0] sum_term, pix_num, mag;
   logic signed [PW-1:0] rnd;
   logic signed [47:0] wdx, three_h;
   logic [63:0] rcp;
   logic signed [DW-1:0] qfin;

   always_comb begin
      st_in = st_ff; k_in = k_ff; z_in = z_ff; neg_in = neg_ff;
      nx_in = nx_ff; ny_in = ny_ff; j_in = j_ff; qx_in = qx_ff; qy_in = qy_ff;
      dq_in = dq_ff; dneg_in = dneg_ff;
      rv_in = rv_ff && rsp_stall;
      ox_in = ox_ff; oy_in = oy_ff; pxo_in = pxo_ff; pyo_in = pyo_ff; on_in = on_ff;
      cstart = 1'b0;
      prod = '0; sum_term = '0; pix_num = '0; mag = '0; rnd = '0; wdx = '0; three_h = '0;
      rcp = '0; qfin = '0;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               k_in = '0;
               st_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod = mk * mu;
            z_in = AW'(prod);
            st_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (SH > 0) z_in = z_ff >>> SH;
            else z_in = z_ff <<< (-SH);
            st_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            // one 2*pi step per cycle until z lies in (-pi, pi]
            if (z_ff > Q30_PI) z_in = z_ff - Q30_TWO_PI;
            else if (z_ff <= -Q30_PI) z_in = z_ff + Q30_TWO_PI;
            else st_in = ST_FOLD;
         end
         ST_FOLD: begin
            neg_in = 1'b0;
            if (z_ff > Q30_HALF_PI) begin z_in = z_ff - Q30_PI; neg_in = 1'b1; end
            else if (z_ff < -Q30_HALF_PI) begin z_in = z_ff + Q30_PI; neg_in = 1'b1; end
            st_in = ST_ROT;
         end
         ST_ROT: begin
            if (cdone) st_in = ST_STORE;
         end
         ST_STORE: begin
            if (k_ff == 2'd3) begin
               st_in = ST_SUM; j_in = 1'b0;
            end else begin
               k_in = k_ff + 2'd1; st_in = ST_MUL;
            end
         end
         ST_SUM: begin
            // x: s0 + c*c1 ; y: s2 + d*c3
            if (!j_ff) sum_term = (PW'(s_ff[0]) <<< FRAC_BITS) + PW'(cc_ff) * PW'(c_ff[1]);
            else       sum_term = (PW'(s_ff[2]) <<< FRAC_BITS) + PW'(cd_ff) * PW'(c_ff[3]);
            rnd = (sum_term + (PW'(1) <<< 29)) >>> 30;
            if (!j_ff) begin
               if (rnd > 32767) nx_in = 16'sh7fff;
               else if (rnd < -32768) nx_in = -16'sh8000;
               else nx_in = 16'(rnd);
               j_in = 1'b1;
            end else begin
               if (rnd > 32767) ny_in = 16'sh7fff;
               else if (rnd < -32768) ny_in = -16'sh8000;
               else ny_in = 16'(rnd);
               j_in = 1'b0;
               st_in = ST_PIX;
            end
         end
         ST_PIX: begin
            wdx = 48'(j_ff ? ny_ff : nx_ff) * $signed({36'd0, sw_ff});
            three_h = $signed({36'd0, (j_ff ? sh_ff : sw_ff)}) * 48'sd3;
            pix_num = PW'(wdx) + (PW'(three_h) <<< FRAC_BITS);
            dneg_in = pix_num[PW-1];
            mag = pix_num[PW-1] ? -pix_num : pix_num;
            // divide by 6*2^F: drop F+1 bits here, divide by 3 next cycle
            dq_in = 32'(mag >>> (FRAC_BITS + 1));
            st_in = ST_DIV;
         end
         ST_DIV: begin
            rcp = dq_ff * 32'hAAAAAAAB;
            qfin = dneg_ff ? -$signed({17'd0, rcp[63:33]}) : $signed({17'd0, rcp[63:33]});
            if (!j_ff) begin
               qx_in = qfin; j_in = 1'b1; st_in = ST_PIX;
            end else begin
               qy_in = qfin; st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               ox_in = nx_ff; oy_in = ny_ff;
               on_in = !qx_ff[DW-1] && (qx_ff < $signed({36'd0, sw_ff})) &&
                       !qy_ff[DW-1] && (qy_ff < $signed({36'd0, sh_ff}));
               pxo_in = (qx_ff > 8191) ? 14'sh1fff :
                        (qx_ff < -8192) ? -14'sh2000 : 14'(qx_ff);
               pyo_in = (qy_ff > 8191) ? 14'sh1fff :
                        (qy_ff < -8192) ? -14'sh2000 : 14'(qy_ff);
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_FOLD) cstart = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         ca_ff <= -16'sd20480; cb_ff <= 16'sd13926;
         cc_ff <= 16'sd9011;  cd_ff <= -16'sd9830;
         sw_ff <= 12'd640; sh_ff <= 12'd480;
         px_ff <= '0; py_ff <= '0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEF_A: ca_ff <= csr_data;
               CSR_COEF_B: cb_ff <= csr_data;
               CSR_COEF_C: cc_ff <= csr_data;
               CSR_COEF_D: cd_ff <= csr_data;
               CSR_WIDTH:  sw_ff <= csr_data[11:0];
               CSR_HEIGHT: sh_ff <= csr_data[11:0];
               default: ;
            endcase
         end
         if (st_ff == ST_IDLE && req_valid && !req_stall && req_restart) begin
            px_ff <= '0; py_ff <= '0;
         end
         if (out_load) begin
            px_ff <= nx_ff; py_ff <= ny_ff;
         end
      end
      k_ff <= k_in; z_ff <= z_in; neg_ff <= neg_in;
      nx_ff <= nx_in; ny_ff <= ny_in; j_ff <= j_in; qx_ff <= qx_in; qy_ff <= qy_in;
      dq_ff <= dq_in; dneg_ff <= dneg_in;
      ox_ff <= ox_in; oy_ff <= oy_in; pxo_ff <= pxo_in; pyo_ff <= pyo_in; on_ff <= on_in;
      if (st_ff == ST_ROT && cdone) begin
         s_ff[k_ff] <= neg_ff ? -csin : csin;
         c_ff[k_ff] <= neg_ff ? -ccos : ccos;
      end
   end
endmodule
`default_nettype wire

>>> sim/tb_pickover_attractor_point_step.sv
`timescale 1ns / 100ps
module tb_pickover_attractor_point_step;
   import pao_pkg::*;

   localparam int  FRAC = 13;
   localparam int  STAGES = 16;
   localparam longint LIMIT = 3000000;

   typedef struct {
      logic signed [15:0] pt_x;
      logic signed [15:0] pt_y;
      logic signed [13:0] pix_x;
      logic signed [13:0] pix_y;
      logic               on_scr;
   } point_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_point_x, rsp_point_y;
   logic signed [13:0] rsp_pixel_x, rsp_pixel_y;
   logic rsp_on_screen;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   pickover_attractor_point_step i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state and register copy
   longint cf_a = -20480, cf_b = 13926, cf_c = 9011, cf_d = -9830;
   longint scr_w = 640, scr_h = 480;
   longint pos_x = 0, pos_y = 0;

   bit             restart_q[$];
   point_beat_type expected_points[$];
   int             send_idle = 0, recv_stall = 0;
   int             mismatches = 0;
   bit             failed = 0;
   bit             req_took = 0;
   longint         cycles = 0;

   longint atan_tbl[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767};

   function automatic void sin_cos(input longint p, output longint s, output longint c);
      longint z, x, y, nx;
      bit neg;
      neg = 0;
      z = p * 16;
      z = z % 64'sd6746518852;
      if (z < 0) z += 64'sd6746518852;
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         neg = 1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         neg = 1;
      end
      x = 652032874;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_tbl[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_tbl[i];
         end
         x = nx;
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
   endfunction

   function automatic longint map_term(longint k, longint u, longint m, longint v);
      longint s1, c1, s2, c2, sum;
      sin_cos(k * u, s1, c1);
      sin_cos(k * v, s2, c2);
      sum = s1 * (64'sd1 << FRAC) + m * c2;
      sum = (sum + (64'sd1 << 29)) >>> 30;
      if (sum < -32768) sum = -32768;
      if (sum > 32767) sum = 32767;
      return sum;
   endfunction

   function automatic longint clip14(longint v);
      return v < -8192 ? -8192 : (v > 8191 ? 8191 : v);
   endfunction

   function automatic point_beat_type attractor_step(bit restart);
      point_beat_type r;
      longint nx, ny, px, py, den;
      if (restart) begin
         pos_x = 0;
         pos_y = 0;
      end
      nx = map_term(cf_a, pos_y, cf_c, pos_x);
      ny = map_term(cf_b, pos_x, cf_d, pos_y);
      pos_x = nx;
      pos_y = ny;
      den = 64'sd6 << FRAC;
      px = (nx * scr_w + (64'sd3 << FRAC) * scr_w) / den;
      py = (ny * scr_w + (64'sd3 << FRAC) * scr_h) / den;
      r.on_scr = px >= 0 && px < scr_w && py >= 0 && py < scr_h;
      r.pt_x = nx[15:0];
      r.pt_y = ny[15:0];
      r.pix_x = 14'(clip14(px));
      r.pix_y = 14'(clip14(py));
      return r;
   endfunction

   // sampling side
   always @(posedge clock) begin
      point_beat_type exp_pt;
      cycles++;
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      req_took = !reset && req_valid && !req_stall;
      if (req_took) expected_points.push_back(attractor_step(req_restart));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat at cycle %0d", cycles);
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_point_x !== exp_pt.pt_x || rsp_point_y !== exp_pt.pt_y ||
                rsp_pixel_x !== exp_pt.pix_x || rsp_pixel_y !== exp_pt.pix_y ||
                rsp_on_screen !== exp_pt.on_scr) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     exp_pt.pt_x, exp_pt.pt_y, exp_pt.pix_x, exp_pt.pix_y, exp_pt.on_scr,
                     rsp_point_x, rsp_point_y, rsp_pixel_x, rsp_pixel_y, rsp_on_screen);
            end
         end
      end
   end

   // driving side
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_took) begin
            if (restart_q.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_restart <= restart_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COEF_A: cf_a = longint'($signed(val));
         CSR_COEF_B: cf_b = longint'($signed(val));
         CSR_COEF_C: cf_c = longint'($signed(val));
         CSR_COEF_D: cf_d = longint'($signed(val));
         CSR_WIDTH:  scr_w = longint'(val[11:0]);
         CSR_HEIGHT: scr_h = longint'(val[11:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (restart_q.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
      // wait longer before touching registers
      repeat (250) @(posedge clock);
   endtask

   initial begin
      logic [15:0] ca, cb, cc, cd, w, h;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: defaults from origin, restarts mid-stream
      for (int i = 0; i < 20; i++) restart_q.push_back(i == 0 || i == 9 || i == 10);
      wait_drained();

      for (int ph = 1; ph <= 9; ph++) begin
         ca = 16'($urandom);
         cb = 16'($urandom);
         cc = 16'($urandom);
         cd = 16'($urandom);
         w = 16'($urandom_range(4095, 1));
         h = 16'($urandom_range(4095, 1));
         case (ph)
            1: begin
               ca = 16'h7fff; cb = 16'h7fff; cc = 16'h7fff; cd = 16'h7fff;
               w = 16'd4095; h = 16'd4095;
            end
            2: begin
               ca = 16'h8000; cb = 16'h8000; cc = 16'h8000; cd = 16'h8000;
               w = 16'd1; h = 16'd1;
            end
            3: w = '0;
            4: h = '0;
            5: begin
               ca = '0; cb = '0;
               w = 16'hf000 | 16'd640; h = 16'hf000 | 16'd480;
            end
            default: ;
         endcase
         // idling modes: sender light / receiver heavy, then swapped, then none
         if (ph <= 3) begin
            send_idle = 17; recv_stall = 67;
         end else if (ph <= 6) begin
            send_idle = 67; recv_stall = 17;
         end else begin
            send_idle = 0; recv_stall = 0;
         end
         csr_write(CSR_COEF_A, ca);
         csr_write(CSR_COEF_B, cb);
         csr_write(CSR_COEF_C, cc);
         csr_write(CSR_COEF_D, cd);
         csr_write(CSR_WIDTH, w);
         csr_write(CSR_HEIGHT, h);
         for (int i = 0; i < 160; i++)
            restart_q.push_back(i == 0 || $urandom_range(99) < 4);
         wait_drained();
      end

      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

>>> pickover_attractor_point_step.f
hdl/pao_pkg.sv
hdl/pao_cordic.sv
hdl/pickover_attractor_point_step.sv
sim/tb_pickover_attractor_point_step.sv
